// ===== rtl/sdes_pkg.sv =====
// ----------------------------------------------------------------------------
// sdes_pkg
// Types, tables and bit permutations shared by the simplified DES counter
// mode cipher.
// ----------------------------------------------------------------------------
package sdes_pkg;

   localparam int KEY_W  = 10;
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 10;

   // configuration register indexes
   localparam logic CSR_CIPHER_KEY      = 1'b0;
   localparam logic CSR_INITIAL_COUNTER = 1'b1;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_of_message;
   } req_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] result_byte;
      logic [BYTE_W-1:0] counter_used;
   } rsp_payload_type;

   typedef struct packed {
      logic [BYTE_W-1:0] k1;
      logic [BYTE_W-1:0] k2;
   } subkeys_type;

   // s-boxes, indexed by {row, col}
   localparam logic [1:0] SBOX0 [0:15] = '{
      2'd1, 2'd0, 2'd3, 2'd2,
      2'd3, 2'd2, 2'd1, 2'd0,
      2'd0, 2'd2, 2'd1, 2'd3,
      2'd3, 2'd1, 2'd3, 2'd2
   };
   localparam logic [1:0] SBOX1 [0:15] = '{
      2'd0, 2'd1, 2'd2, 2'd3,
      2'd2, 2'd0, 2'd1, 2'd3,
      2'd3, 2'd0, 2'd1, 2'd0,
      2'd2, 2'd1, 2'd0, 2'd3
   };

   // permutations, table position 1 is the msb of the source value
   function automatic logic [9:0] perm_p10(input logic [9:0] k);
      return {k[8], k[6], k[9], k[4], k[7], k[1], k[5], k[0], k[3], k[2]};
   endfunction

   function automatic logic [7:0] perm_p8(input logic [9:0] k);
      return {k[4], k[7], k[3], k[6], k[2], k[5], k[0], k[1]};
   endfunction

   function automatic logic [7:0] perm_ip(input logic [7:0] b);
      return {b[6], b[2], b[5], b[7], b[4], b[0], b[3], b[1]};
   endfunction

   function automatic logic [7:0] perm_ipinv(input logic [7:0] b);
      return {b[4], b[7], b[5], b[3], b[1], b[6], b[0], b[2]};
   endfunction

   function automatic logic [7:0] perm_ep(input logic [3:0] n);
      return {n[0], n[3], n[2], n[1], n[2], n[1], n[0], n[3]};
   endfunction

   function automatic logic [3:0] perm_p4(input logic [3:0] n);
      return {n[2], n[0], n[1], n[3]};
   endfunction

   // row from outer bits, column from inner bits
   function automatic logic [3:0] sbox_idx(input logic [3:0] n);
      return {n[3], n[0], n[2], n[1]};
   endfunction

endpackage

// ===== rtl/sdes_ctr_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// sdes_ctr_stream_cipher
// Simplified DES in counter mode over a byte stream.
// ----------------------------------------------------------------------------
// usage:
//   csr port: write cipher_key (index 0) and initial_counter (index 1) while
//   the block is idle; writes take effect for the next request
//   request channel: one data byte per request; first_of_message reloads the
//   running counter from initial_counter before that byte
//   response channel: result_byte = data_byte xor sdes(key, counter_used)
//   response path: the input register loads on accept and the result register
//   loads from it when not stalled; rsp_valid follows the result register
//   throughput: one byte per cycle while rsp_stall is low; the whole cipher is one pass of
//   permutation wiring and s-box lookups between the two registers
//   stall: rsp_stall freezes the result register; the input stage still
//   takes one more request if empty, then req_stall rises
//   reset: counter, key and initial counter clear to zero, pipeline empties
//   encryption and decryption are the same operation
// ----------------------------------------------------------------------------
module sdes_ctr_stream_cipher import sdes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   // request channel
   input  logic              req_valid,
   output logic              req_stall,
   input  req_payload_type   req_payload,
   // response channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_payload_type   rsp_payload,
   // configuration
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data
);

   // configuration registers
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [BYTE_W-1:0] init_ctr_ff, init_ctr_in;

   // running counter
   logic [BYTE_W-1:0] run_ctr_ff, run_ctr_in;
   logic [BYTE_W-1:0] ctr_sel;

   // input stage
   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_data_ff, s1_data_in;
   logic [BYTE_W-1:0] s1_ctr_ff, s1_ctr_in;

   // result stage
   logic              out_valid_ff, out_valid_in;
   rsp_payload_type   out_ff, out_in;

   logic              req_accept, out_load, s1_load;
   subkeys_type       subkeys;
   logic [BYTE_W-1:0] keystream;

   sdes_key_sched u_key_sched (
      .cipher_key (key_ff),
      .subkeys    (subkeys)
   );

   sdes_encipher u_encipher (
      .block_in  (s1_ctr_ff),
      .subkeys   (subkeys),
      .block_out (keystream)
   );

   // pipeline advance
   assign out_load   = !out_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || out_load;
   assign req_stall  = !s1_load;
   assign req_accept = req_valid && s1_load;

   // counter chosen for this byte
   assign ctr_sel = req_payload.first_of_message ? init_ctr_ff : run_ctr_ff;

   always_comb begin
      key_in      = key_ff;
      init_ctr_in = init_ctr_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_CIPHER_KEY:      key_in      = csr_wr_data[KEY_W-1:0];
            CSR_INITIAL_COUNTER: init_ctr_in = csr_wr_data[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      run_ctr_in  = run_ctr_ff;
      s1_valid_in = s1_valid_ff;
      s1_data_in  = s1_data_ff;
      s1_ctr_in   = s1_ctr_ff;
      if (s1_load) begin
         s1_valid_in = req_valid;
      end
      if (req_accept) begin
         s1_data_in = req_payload.data_byte;
         s1_ctr_in  = ctr_sel;
         // wraps past 255 to 0
         run_ctr_in = ctr_sel + BYTE_W'(1);
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (out_load) begin
         out_valid_in = s1_valid_ff;
         if (s1_valid_ff) begin
            out_in.result_byte  = s1_data_ff ^ keystream;
            out_in.counter_used = s1_ctr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         init_ctr_ff  <= '0;
         run_ctr_ff   <= '0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         init_ctr_ff  <= init_ctr_in;
         run_ctr_ff   <= run_ctr_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_data_ff <= s1_data_in;
      s1_ctr_ff  <= s1_ctr_in;
      out_ff     <= out_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

`ifndef SYNTHESIS
   // a restart uses the initial counter
   assert property (@(posedge clock) disable iff (reset)
      req_accept && req_payload.first_of_message |=> s1_ctr_ff == $past(init_ctr_ff))
      else $error("restart did not load initial counter");

   // a continuing byte uses the running counter
   assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_payload.first_of_message |=> s1_ctr_ff == $past(run_ctr_ff))
      else $error("continuing byte did not use running counter");

   // counter steps by one after each accepted request
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> run_ctr_ff == s1_ctr_ff + BYTE_W'(1))
      else $error("running counter not incremented");

   // an item leaving the input stage shows up at the result register
   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && out_load |=> rsp_valid && rsp_payload.counter_used == $past(s1_ctr_ff))
      else $error("item lost between stages");
`endif

endmodule

// ===== rtl/sdes_key_sched.sv =====
// ----------------------------------------------------------------------------
// sdes_key_sched
// Derives the two round subkeys from the ten-bit key (p10, rotates, p8).
// ----------------------------------------------------------------------------
module sdes_key_sched import sdes_pkg::*; (
   input  logic [KEY_W-1:0] cipher_key,
   output subkeys_type      subkeys
);

   logic [9:0] p;
   logic [4:0] hi1, lo1, hi3, lo3;

   always_comb begin
      p   = perm_p10(cipher_key);
      // left rotate by one, then by two more
      hi1 = {p[8:5], p[9]};
      lo1 = {p[3:0], p[4]};
      hi3 = {hi1[2:0], hi1[4:3]};
      lo3 = {lo1[2:0], lo1[4:3]};
      subkeys.k1 = perm_p8({hi1, lo1});
      subkeys.k2 = perm_p8({hi3, lo3});
   end

endmodule

// ===== rtl/sdes_encipher.sv =====
// ----------------------------------------------------------------------------
// sdes_encipher
// Two-round simplified DES encryption of one byte.
// ----------------------------------------------------------------------------
module sdes_encipher import sdes_pkg::*; (
   input  logic [BYTE_W-1:0] block_in,
   input  subkeys_type       subkeys,
   output logic [BYTE_W-1:0] block_out
);

   function automatic logic [3:0] round_f(input logic [3:0] half, input logic [7:0] sk);
      logic [7:0] e;
      logic [3:0] s;
      e = perm_ep(half) ^ sk;
      s = {SBOX0[sbox_idx(e[7:4])], SBOX1[sbox_idx(e[3:0])]};
      return perm_p4(s);
   endfunction

   logic [7:0] x;
   logic [3:0] l1, left_h;

   always_comb begin
      x         = perm_ip(block_in);
      l1        = x[7:4] ^ round_f(x[3:0], subkeys.k1);
      // halves swapped for the second round
      left_h    = x[3:0] ^ round_f(l1, subkeys.k2);
      block_out = perm_ipinv({left_h, l1});
   end

endmodule

// ===== sim/sdes_ctr_checker.sv =====
// ----------------------------------------------------------------------------
// sdes_ctr_checker
// Watches the request, response and csr ports of the s-des counter mode
// cipher, predicts every response from its own copy of key, initial counter
// and running counter, and compares each response field by field in order.
// ----------------------------------------------------------------------------
module sdes_ctr_checker import sdes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_stall,
   input  req_payload_type   req_payload,
   input  logic              rsp_valid,
   input  logic              rsp_stall,
   input  rsp_payload_type   rsp_payload,
   input  logic              csr_wr_en,
   input  logic              csr_index,
   input  logic [CSR_W-1:0]  csr_wr_data,
   output int                failures,
   output int                backlog
);
   timeunit 1ns;
   timeprecision 1ps;

   // wiring maps, one nibble per output bit, first output bit in the top nibble
   localparam logic [39:0] P10_MAP   = {4'd2, 4'd4, 4'd1, 4'd6, 4'd3, 4'd9, 4'd5,
                                        4'd10, 4'd7, 4'd8};
   localparam logic [39:0] P8_MAP    = {4'd6, 4'd3, 4'd7, 4'd4, 4'd8, 4'd5, 4'd10,
                                        4'd9, 8'd0};
   localparam logic [39:0] IP_MAP    = {4'd2, 4'd6, 4'd3, 4'd1, 4'd4, 4'd8, 4'd5,
                                        4'd7, 8'd0};
   localparam logic [39:0] IPINV_MAP = {4'd4, 4'd1, 4'd3, 4'd5, 4'd7, 4'd2, 4'd8,
                                        4'd6, 8'd0};
   localparam logic [39:0] EP_MAP    = {4'd4, 4'd1, 4'd2, 4'd3, 4'd2, 4'd3, 4'd4,
                                        4'd1, 8'd0};
   localparam logic [39:0] P4_MAP    = {4'd2, 4'd4, 4'd3, 4'd1, 24'd0};

   // s-boxes, two bits per entry, row-major, entry 0 in the top bits
   localparam logic [31:0] S0_BOX = {2'd1, 2'd0, 2'd3, 2'd2, 2'd3, 2'd2, 2'd1, 2'd0,
                                     2'd0, 2'd2, 2'd1, 2'd3, 2'd3, 2'd1, 2'd3, 2'd2};
   localparam logic [31:0] S1_BOX = {2'd0, 2'd1, 2'd2, 2'd3, 2'd2, 2'd0, 2'd1, 2'd3,
                                     2'd3, 2'd0, 2'd1, 2'd0, 2'd2, 2'd1, 2'd0, 2'd3};

   rsp_payload_type   expected_q[$];
   rsp_payload_type   due;
   rsp_payload_type   seen;
   logic [KEY_W-1:0]  key_copy;
   logic [BYTE_W-1:0] start_count;
   logic [BYTE_W-1:0] counter_copy;
   int                mismatch_total = 0;

   // bit positions count from 1 at the msb of a src_w wide source
   function automatic logic [9:0] rewire(input logic [9:0] src, input int src_w,
                                         input logic [39:0] map, input int n);
      logic [9:0] dst;
      int         pos;
      dst = '0;
      for (int i = 0; i < n; i++) begin
         pos = map[39-4*i -: 4];
         dst = {dst[8:0], src[src_w-pos]};
      end
      return dst;
   endfunction

   function automatic logic [4:0] rotl5(input logic [4:0] x, input int by);
      for (int i = 0; i < by; i++) x = {x[3:0], x[4]};
      return x;
   endfunction

   // row from the outer bits, column from the inner two
   function automatic logic [1:0] sbox_out(input logic [31:0] box, input logic [3:0] nib);
      int idx;
      idx = {nib[3], nib[0], nib[2], nib[1]};
      return box[31-2*idx -: 2];
   endfunction

   function automatic logic [3:0] feistel_f(input logic [3:0] half, input logic [7:0] subkey);
      logic [9:0] wide;
      logic [7:0] mixed;
      logic [3:0] boxed;
      wide  = rewire({6'd0, half}, 4, EP_MAP, 8);
      mixed = wide[7:0] ^ subkey;
      boxed = {sbox_out(S0_BOX, mixed[7:4]), sbox_out(S1_BOX, mixed[3:0])};
      wide  = rewire({6'd0, boxed}, 4, P4_MAP, 4);
      return wide[3:0];
   endfunction

   function automatic logic [7:0] sdes_encipher(input logic [7:0] block,
                                                input logic [KEY_W-1:0] key);
      logic [9:0] wide;
      logic [4:0] hi, lo;
      logic [7:0] k1, k2;
      logic [3:0] left, right, mid;
      wide  = rewire(key, 10, P10_MAP, 10);
      hi    = rotl5(wide[9:5], 1);
      lo    = rotl5(wide[4:0], 1);
      wide  = rewire({hi, lo}, 10, P8_MAP, 8);
      k1    = wide[7:0];
      hi    = rotl5(hi, 2);
      lo    = rotl5(lo, 2);
      wide  = rewire({hi, lo}, 10, P8_MAP, 8);
      k2    = wide[7:0];
      wide  = rewire({2'd0, block}, 8, IP_MAP, 8);
      left  = wide[7:4];
      right = wide[3:0];
      mid   = left ^ feistel_f(right, k1);
      left  = right ^ feistel_f(mid, k2);
      wide  = rewire({2'd0, left, mid}, 8, IPINV_MAP, 8);
      return wide[7:0];
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         key_copy     = '0;
         start_count  = '0;
         counter_copy = '0;
         expected_q.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_CIPHER_KEY:      key_copy = csr_wr_data[KEY_W-1:0];
               CSR_INITIAL_COUNTER: start_count = csr_wr_data[BYTE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            if (req_payload.first_of_message) counter_copy = start_count;
            due.counter_used = counter_copy;
            due.result_byte  = req_payload.data_byte ^ sdes_encipher(counter_copy, key_copy);
            expected_q.push_back(due);
            counter_copy = counter_copy + 8'd1;
         end
         if (rsp_valid && !rsp_stall) begin
            seen = rsp_payload;
            if (expected_q.size() == 0) begin
               $error("unexpected response: result_byte %02h counter_used %02h",
                      seen.result_byte, seen.counter_used);
               mismatch_total++;
            end else begin
               due = expected_q.pop_front();
               if (seen.result_byte !== due.result_byte) begin
                  $error("result_byte: expected %02h, got %02h",
                         due.result_byte, seen.result_byte);
                  mismatch_total++;
               end
               if (seen.counter_used !== due.counter_used) begin
                  $error("counter_used: expected %02h, got %02h",
                         due.counter_used, seen.counter_used);
                  mismatch_total++;
               end
            end
         end
      end
      failures <= mismatch_total;
      backlog  <= expected_q.size();
   end

endmodule

// ===== sim/sdes_ctr_stream_cipher_tb.sv =====
// ----------------------------------------------------------------------------
// sdes_ctr_stream_cipher_tb
// Drives byte requests and csr writes into the s-des counter mode cipher
// with random gaps and response stalls; the checker beside the block
// predicts and compares every response, this top only reports the verdict.
// ----------------------------------------------------------------------------
module sdes_ctr_stream_cipher_tb;
   import sdes_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 105;
   localparam int LONG_HOLD   = 200;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   req_payload_type   req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   rsp_payload_type   rsp_payload;
   logic              csr_wr_en   = 1'b0;
   logic              csr_index   = CSR_CIPHER_KEY;
   logic [CSR_W-1:0]  csr_wr_data = '0;

   int                failures;
   int                backlog;
   bit                send_quiet  = 1'b0;   // no gaps between requests while set

   sdes_ctr_stream_cipher DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   sdes_ctr_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .failures    (failures),
      .backlog     (backlog)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // every task below is entered and left right after a rising edge

   // one request: optional gap with valid low, then hold until taken; valid
   // stays high across back-to-back requests so it never toggles in one step
   task automatic send_byte(input logic [7:0] data, input logic first);
      int gap;
      gap = send_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid                    <= 1'b1;
      req_payload.data_byte        <= data;
      req_payload.first_of_message <= first;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // a message of random bytes; without restart the counter just runs on
   task automatic send_message(input int len, input bit restart);
      send_quiet = ($urandom_range(0, 4) == 0);
      for (int i = 0; i < len; i++) begin
         send_byte(8'($urandom_range(0, 255)), (i == 0) && restart);
      end
   endtask

   // valid low until all responses from the two pipeline stages are in
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (backlog != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // both registers back to back; spare upper bits of the counter write are junk
   task automatic load_config(input logic [9:0] key, input logic [7:0] start);
      logic [1:0] junk;
      junk = 2'($urandom_range(0, 3));
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_CIPHER_KEY;
      csr_wr_data <= key;
      @(posedge clock);
      csr_index   <= CSR_INITIAL_COUNTER;
      csr_wr_data <= {junk, start};
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // response side: random stall per response, quiet stretches, and two
   // long hold-offs that back the pipeline up into the request side
   initial begin
      int  taken;
      int  hold;
      bit  rsp_quiet;
      taken     = 0;
      rsp_quiet = 1'b0;
      wait (reset == 1'b0);
      @(posedge clock);
      forever begin
         if (taken % 50 == 0) rsp_quiet = ($urandom_range(0, 3) == 0);
         if (taken == 150 || taken == 500) hold = LONG_HOLD;
         else hold = rsp_quiet ? 0 : $urandom_range(0, 15);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         taken++;
      end
   end

   // request side and verdict
   initial begin
      int         left_in_phase;
      int         len;
      logic [9:0] key;
      logic [7:0] start;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values: key 0, and no start flag so the counter runs from 0
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'ha5, 1'b0);
      wait_drained();

      // all-ones key, counter wraps from 254 through 255 to 0 and 1
      load_config(10'h3ff, 8'hfe);
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
      send_byte(8'h3c, 1'b0);
      wait_drained();

      // key change mid-message: counter keeps going, new key applies at once
      load_config(10'b1010000010, 8'h10);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      // restart twice in a row, then once more after a couple of bytes
      send_byte(8'h7f, 1'b1);
      send_byte(8'hfe, 1'b1);
      send_byte(8'h55, 1'b0);
      send_byte(8'haa, 1'b0);
      send_byte(8'h0f, 1'b1);
      wait_drained();

      // random phases: mostly restarted messages, some that just run on,
      // now and then a longer one, capped at the bytes left in the phase
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin key = 10'h000; start = 8'hff; end
            1:       begin key = 10'h3ff; start = 8'h00; end
            default: begin
               key   = 10'($urandom_range(0, 1023));
               start = 8'($urandom_range(0, 255));
            end
         endcase
         load_config(key, start);
         left_in_phase = PHASE_ITEMS;
         while (left_in_phase > 0) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 300)
                                              : $urandom_range(1, 24);
            if (len > left_in_phase) len = left_in_phase;
            send_message(len, $urandom_range(0, 7) != 0);
            left_in_phase -= len;
         end
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
